@@ design/psl_pkg.sv @@
// Package for the servo position loop: default parameters, reset values,
// register indices, the queue entry type and the sequencer state type. Used by every module in the design folder.
package psl_pkg;
  localparam int CommandTapsDef = 32;
  localparam int MedianTapsDef  = 7;
  localparam int DerivLagDef    = 3;
  localparam int DutyLimitDef   = 1000;

  localparam logic signed [15:0] KpReset  = 16'sd2000;
  localparam logic signed [15:0] KiReset  = 16'sd20;
  localparam logic signed [15:0] KdReset  = 16'sd6000;
  localparam logic [9:0]         OffReset = 10'd30;

  localparam logic [2:0] RegKp  = 3'd0;
  localparam logic [2:0] RegKi  = 3'd1;
  localparam logic [2:0] RegKd  = 3'd2;
  localparam logic [2:0] RegOff = 3'd3;
  localparam logic [2:0] RegRun = 3'd4;

  // One classified item handed from the front part to the back part.
  typedef struct packed {
    logic       run;
    logic [9:0] cmd;
    logic [9:0] fb;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RING, ST_AVG, ST_MED, ST_ERR, ST_INT, ST_MUL_P, ST_MUL_I,
    ST_MUL_I2, ST_MUL_D, ST_SUM, ST_DIV, ST_OUT
  } back_state_t;
endpackage

@@ design/psl_front.sv @@
// Front part: takes input transactions, tags them with run_enable and pushes
// them into a two-entry queue. Depends on psl_pkg.
module psl_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              run,
  input  logic              s_valid,
  output logic              s_ready,
  input  logic [9:0]        s_cmd,
  input  logic [9:0]        s_fb,
  input  logic              pop,
  output logic              q_valid,
  output psl_pkg::item_t    q_item
);
  psl_pkg::item_t mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push;

  assign s_ready = (count != 2'd2);
  assign push    = s_valid && s_ready;
  assign q_valid = (count != 2'd0);
  assign q_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{run: run, cmd: s_cmd, fb: s_fb};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

@@ design/psl_back.sv @@
// Back part: filters, PID arithmetic and the output register, worked out step
// by step by a sequencer. Depends on psl_pkg.
module psl_back #(
  parameter int COMMAND_TAPS = psl_pkg::CommandTapsDef,
  parameter int MEDIAN_TAPS  = psl_pkg::MedianTapsDef,
  parameter int DERIV_LAG    = psl_pkg::DerivLagDef,
  parameter int DUTY_LIMIT   = psl_pkg::DutyLimitDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic signed [15:0]  kp,
  input  logic signed [15:0]  ki,
  input  logic signed [15:0]  kd,
  input  logic [9:0]          offset,
  input  logic                q_valid,
  input  psl_pkg::item_t      q_item,
  output logic                pop,
  output logic                m_valid,
  input  logic                m_ready,
  output logic [9:0]          m_duty,
  output logic                m_dir,
  output logic                m_clamped
);
  localparam int CW = (COMMAND_TAPS > 1) ? $clog2(COMMAND_TAPS) : 1;
  localparam int MW = (MEDIAN_TAPS > 1) ? $clog2(MEDIAN_TAPS) : 1;
  localparam int LW = (DERIV_LAG > 1) ? $clog2(DERIV_LAG) : 1;
  localparam int TW = 10 + $clog2(COMMAND_TAPS + 1);
  localparam int MID = (MEDIAN_TAPS - 1) / 2;
  localparam int SW = 4;

  psl_pkg::back_state_t state, state_next;

  logic [9:0]  ring [COMMAND_TAPS];
  logic [CW-1:0] cslot;
  logic [TW-1:0] total;
  logic [9:0]  ring_old;
  logic [9:0]  win [MEDIAN_TAPS];
  logic [MW-1:0] fslot;
  logic signed [10:0] past [DERIV_LAG];
  logic [LW-1:0] pslot;
  logic signed [31:0] integ;
  logic        was_clamped;
  logic [9:0]  avg, med;
  logic signed [10:0] err, lagged;
  logic signed [47:0] acc;
  logic signed [47:0] prod;
  logic signed [39:0] corr;
  logic [9:0]  cmd_r, fb_r;
  logic        out_full;

  // Rank of the candidate: counts of smaller and of equal window entries.
  logic [SW-1:0] less_cnt, eq_cnt;
  logic [MW-1:0] med_idx;
  always_comb begin
    less_cnt = '0;
    eq_cnt   = '0;
    for (int i = 0; i < MEDIAN_TAPS; i++) begin
      if (win[i] < win[med_idx]) less_cnt = less_cnt + 1'b1;
      if (win[i] == win[med_idx]) eq_cnt = eq_cnt + 1'b1;
    end
  end

  logic signed [32:0] integ_sum;
  logic signed [11:0] dlt;
  assign integ_sum = {integ[31], integ} + 33'(err);
  assign dlt = 12'(err) - 12'(lagged);

  logic signed [47:0] q256;
  assign q256 = (acc + ((acc < 0) ? 48'sd255 : 48'sd0)) >>> 8;

  logic signed [40:0] drive;
  assign drive = 41'(corr) + 41'(signed'({1'b0, offset}));

  always_comb begin
    state_next = state;
    pop = 1'b0;
    unique case (state)
      psl_pkg::ST_IDLE:
        if (q_valid && !out_full) begin
          pop = 1'b1;
          state_next = q_item.run ? psl_pkg::ST_RING : psl_pkg::ST_OUT;
        end
      psl_pkg::ST_RING:  state_next = psl_pkg::ST_AVG;
      psl_pkg::ST_AVG:   state_next = psl_pkg::ST_MED;
      psl_pkg::ST_MED:
        if ((32'(less_cnt) <= MID) && (32'(less_cnt) + 32'(eq_cnt) > MID))
          state_next = psl_pkg::ST_ERR;
      psl_pkg::ST_ERR:   state_next = psl_pkg::ST_INT;
      psl_pkg::ST_INT:   state_next = psl_pkg::ST_MUL_P;
      psl_pkg::ST_MUL_P: state_next = psl_pkg::ST_MUL_I;
      psl_pkg::ST_MUL_I: state_next = psl_pkg::ST_MUL_I2;
      psl_pkg::ST_MUL_I2: state_next = psl_pkg::ST_MUL_D;
      psl_pkg::ST_MUL_D: state_next = psl_pkg::ST_SUM;
      psl_pkg::ST_SUM:   state_next = psl_pkg::ST_DIV;
      psl_pkg::ST_DIV:   state_next = psl_pkg::ST_OUT;
      psl_pkg::ST_OUT:   state_next = psl_pkg::ST_IDLE;
      default:           state_next = psl_pkg::ST_IDLE;
    endcase
  end

  assign m_valid = out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psl_pkg::ST_IDLE;
      out_full <= 1'b0;
      cslot <= '0;
      total <= '0;
      fslot <= '0;
      pslot <= '0;
      integ <= '0;
      was_clamped <= 1'b0;
      for (int i = 0; i < COMMAND_TAPS; i++) ring[i] <= '0;
      for (int i = 0; i < MEDIAN_TAPS; i++) win[i] <= '0;
      for (int i = 0; i < DERIV_LAG; i++) past[i] <= '0;
      corr <= '0;
    end else begin
      state <= state_next;
      if (m_valid && m_ready) out_full <= 1'b0;
      unique case (state)
        psl_pkg::ST_IDLE:
          if (pop) begin
            cmd_r <= q_item.cmd;
            fb_r  <= q_item.fb;
            ring_old <= ring[cslot];
            if (!q_item.run) corr <= '0;
          end
        psl_pkg::ST_RING: begin
          total <= total - TW'(ring_old) + TW'(cmd_r);
          ring[cslot] <= cmd_r;
          cslot <= (32'(cslot) == COMMAND_TAPS - 1) ? '0 : cslot + 1'b1;
          win[fslot] <= fb_r;
          fslot <= (32'(fslot) == MEDIAN_TAPS - 1) ? '0 : fslot + 1'b1;
          med_idx <= '0;
        end
        psl_pkg::ST_AVG: avg <= 10'(total / COMMAND_TAPS);
        psl_pkg::ST_MED:
          if (state_next == psl_pkg::ST_ERR) med <= win[med_idx];
          else med_idx <= med_idx + 1'b1;
        psl_pkg::ST_ERR: begin
          err <= 11'(signed'({1'b0, med})) - 11'(signed'({1'b0, avg}));
          lagged <= past[pslot];
        end
        psl_pkg::ST_INT: begin
          if (!was_clamped) begin
            if (integ_sum > 33'sh07FFFFFFF) integ <= 32'sh7FFFFFFF;
            else if (integ_sum < -33'sh080000000) integ <= 32'sh80000000;
            else integ <= integ_sum[31:0];
          end
          past[pslot] <= err;
          pslot <= (32'(pslot) == DERIV_LAG - 1) ? '0 : pslot + 1'b1;
          prod <= 48'(err) * 48'(kp);
        end
        psl_pkg::ST_MUL_P: begin
          acc <= prod;
          prod <= 48'(signed'({1'b0, integ[15:0]})) * 48'(ki);
        end
        psl_pkg::ST_MUL_I: begin
          acc <= acc + prod;
          prod <= (48'(signed'(integ[31:16])) * 48'(ki)) <<< 16;
        end
        psl_pkg::ST_MUL_I2: begin
          acc <= acc + prod;
          prod <= 48'(dlt) * 48'(kd);
        end
        psl_pkg::ST_MUL_D: acc <= acc + prod;
        psl_pkg::ST_SUM: acc <= q256;
        psl_pkg::ST_DIV: begin
          if (acc > 48'(DUTY_LIMIT)) begin
            corr <= 40'(DUTY_LIMIT);
            was_clamped <= 1'b1;
          end else if (acc < -48'(DUTY_LIMIT)) begin
            corr <= -40'(DUTY_LIMIT);
            was_clamped <= 1'b1;
          end else begin
            corr <= acc[39:0];
            was_clamped <= 1'b0;
          end
        end
        psl_pkg::ST_OUT: out_full <= 1'b1;
        default: ;
      endcase
    end
  end

  // Output register: filled in ST_OUT from the clamped correction plus the offset, or zero for a disabled item.
  logic run_item;
  always_ff @(posedge clk) begin
    if (state == psl_pkg::ST_IDLE && pop) run_item <= q_item.run;
    if (state == psl_pkg::ST_OUT) begin
      if (!run_item) begin
        m_duty <= '0;
        m_dir <= 1'b0;
        m_clamped <= 1'b0;
      end else begin
        m_clamped <= was_clamped;
        if (drive < 0) begin
          m_dir <= 1'b1;
          m_duty <= (-drive > 41'(DUTY_LIMIT)) ? 10'(DUTY_LIMIT) : 10'(-drive);
        end else begin
          m_dir <= 1'b0;
          m_duty <= (drive > 41'(DUTY_LIMIT)) ? 10'(DUTY_LIMIT) : 10'(drive);
        end
      end
    end
  end
endmodule

@@ design/pid_servo_position_loop.sv @@
// Top level of the servo position loop: configuration registers, the front
// queue and the back sequencer. Depends on psl_pkg, psl_front, psl_back.
//
// Usage: one input transaction per control tick carries the command and
// feedback samples; one output transaction returns duty, direction and the
// clamp flag. The configuration channel writes the gains, the offset and
// run_enable by register index; write it only while the block is idle.
// An enabled item runs through the filter, PID and output steps in turn,
// with a median search that steps one window candidate a cycle; a disabled
// item skips the filter and PID steps and goes straight to the output. A new item
// starts only after the previous result has been taken, so the back part
// never takes an item before it is through with the last one.
// A two-entry queue lets the input side keep taking items while the
// receiver stalls; once full, s_axis_tready drops. Reset clears all filter
// and PID state and loads the default register values.
module pid_servo_position_loop #(
  parameter int COMMAND_TAPS = psl_pkg::CommandTapsDef,
  parameter int MEDIAN_TAPS  = psl_pkg::MedianTapsDef,
  parameter int DERIV_LAG    = psl_pkg::DerivLagDef,
  parameter int DUTY_LIMIT   = psl_pkg::DutyLimitDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // command_sample[9:0], feedback_sample[19:10]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // duty[9:0], direction[10], clamped[11]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  logic signed [15:0] kp, ki, kd;
  logic [9:0] offset;
  logic run;
  logic q_valid, pop;
  psl_pkg::item_t q_item;
  logic [9:0] duty;
  logic dir, clamped;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp <= psl_pkg::KpReset;
      ki <= psl_pkg::KiReset;
      kd <= psl_pkg::KdReset;
      offset <= psl_pkg::OffReset;
      run <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        psl_pkg::RegKp:  kp <= cfg_data;
        psl_pkg::RegKi:  ki <= cfg_data;
        psl_pkg::RegKd:  kd <= cfg_data;
        psl_pkg::RegOff: offset <= cfg_data[9:0];
        psl_pkg::RegRun: run <= cfg_data[0];
        default: ;
      endcase
    end
  end

  psl_front u_front (
    .clk(clk), .rst(rst), .run(run),
    .s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
    .s_cmd(s_axis_tdata[9:0]), .s_fb(s_axis_tdata[19:10]),
    .pop(pop), .q_valid(q_valid), .q_item(q_item)
  );

  psl_back #(
    .COMMAND_TAPS(COMMAND_TAPS), .MEDIAN_TAPS(MEDIAN_TAPS),
    .DERIV_LAG(DERIV_LAG), .DUTY_LIMIT(DUTY_LIMIT)
  ) u_back (
    .clk(clk), .rst(rst), .kp(kp), .ki(ki), .kd(kd), .offset(offset),
    .q_valid(q_valid), .q_item(q_item), .pop(pop),
    .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
    .m_duty(duty), .m_dir(dir), .m_clamped(clamped)
  );

  assign m_axis_tdata = {4'b0, clamped, dir, duty};
endmodule
